// ----- hdl/mprh_pkg.sv -----
// Shared constants, payload types and a helper function of the median predictor block.
`default_nettype none

package mprh_pkg;

  // Sizing of the line history and of the histogram counters.
  localparam int unsigned MAX_ROW_WIDTH = 4096;
  localparam int unsigned COUNT_WIDTH   = 32;
  localparam int unsigned HIST_DEPTH    = MAX_ROW_WIDTH + 1;
  localparam int unsigned HIST_AW       = $clog2(HIST_DEPTH);
  localparam int unsigned POS_W         = $clog2(MAX_ROW_WIDTH + 2);
  localparam int unsigned ROW_WIDTH_W   = 13;
  localparam int unsigned CMP_W         = (POS_W > ROW_WIDTH_W) ? POS_W : ROW_WIDTH_W;

  localparam int unsigned SAMPLE_W    = 8;
  localparam int unsigned BIN_W       = 8;
  localparam int unsigned BINS        = 1 << BIN_W;
  localparam int unsigned BIN_COUNT_W = 32;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SAMPLE_W-1:0]    FIRST_PREDICTION = 8'h80;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET  = 13'd1920;

  // Operation codes of an input item.
  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_READ    = 1'b1;

  // Kinds of a result item.
  localparam logic RK_RESIDUAL = 1'b0;
  localparam logic RK_BIN      = 1'b1;

  typedef struct packed {
    logic                opcode;
    logic [SAMPLE_W-1:0] sample;
    logic                first_of_plane;
    logic [BIN_W-1:0]    bin_index;
    logic                clear_bin;
  } in_item_t;

  typedef struct packed {
    logic                   result_kind;
    logic [SAMPLE_W-1:0]    residual;
    logic [BIN_COUNT_W-1:0] bin_count;
  } out_item_t;

  // Histogram operation handed from the front end to the back end.
  typedef struct packed {
    logic             opcode;
    logic [BIN_W-1:0] bin;
    logic             clear_bin;
  } hist_op_t;

  function automatic logic [SAMPLE_W-1:0] med3(input logic [SAMPLE_W-1:0] a,
                                               input logic [SAMPLE_W-1:0] b,
                                               input logic [SAMPLE_W-1:0] c);
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] m;
    hi = (a > b) ? a : b;
    lo = (a > b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (m > lo) ? m : lo;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/mprh_front.sv -----
// Front end: accepts items, keeps the sample history and computes the residual.
`default_nettype none

module mprh_front
  import mprh_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire in_item_t               in_data_i,
  input  wire logic [ROW_WIDTH_W-1:0] row_width_i,
  input  wire logic                   predict_mode_i,
  output logic                        op_valid_o,
  input  wire logic                   op_ready_i,
  output hist_op_t                    op_o
);

  localparam int unsigned AX_W = HIST_AW + 1;

  localparam logic [1:0] SEL_FIRST  = 2'd0;
  localparam logic [1:0] SEL_LEFT   = 2'd1;
  localparam logic [1:0] SEL_ABOVE  = 2'd2;
  localparam logic [1:0] SEL_MEDIAN = 2'd3;

  logic                accept;
  logic                pred_acc;
  logic [CMP_W-1:0]    rw_c;
  logic [POS_W-1:0]    w_eff;
  logic [POS_W-1:0]    w_plus1;
  logic [POS_W-1:0]    pos_cur;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [1:0]          sel;
  logic [HIST_AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AX_W-1:0]     base, above_raw, ul_raw;
  logic [HIST_AW-1:0]  above_addr, ul_addr;
  logic [SAMPLE_W-1:0] last_q;

  logic [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];
  logic [SAMPLE_W-1:0] above_q, ul_q;

  logic                s1_v_q, s1_v_d;
  logic                s1_op_q;
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic [SAMPLE_W-1:0] s1_left_q;
  logic [1:0]          s1_sel_q;
  logic [BIN_W-1:0]    s1_bin_q;
  logic                s1_clear_q;

  logic [SAMPLE_W-1:0] grad;
  logic [SAMPLE_W-1:0] pred;
  logic [SAMPLE_W-1:0] resid;

  assign in_ready_o = !s1_v_q || op_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign pred_acc   = accept && (in_data_i.opcode == OP_PREDICT);

  // Effective row width, clamped into the supported range.
  always_comb begin
    rw_c = CMP_W'(row_width_i);
    if (rw_c == '0) begin
      w_eff = POS_W'(1);
    end else if (rw_c > CMP_W'(MAX_ROW_WIDTH)) begin
      w_eff = POS_W'(MAX_ROW_WIDTH);
    end else begin
      w_eff = POS_W'(rw_c);
    end
    w_plus1 = w_eff + POS_W'(1);
  end

  // Position in the plane selects the predictor.
  always_comb begin
    pos_cur = in_data_i.first_of_plane ? '0 : pos_q;
    if (pos_cur == '0) begin
      sel = SEL_FIRST;
    end else if (predict_mode_i || (pos_cur < w_eff)) begin
      sel = SEL_LEFT;
    end else if (pos_cur == w_eff) begin
      sel = SEL_ABOVE;
    end else begin
      sel = SEL_MEDIAN;
    end
    pos_d = (pos_cur < w_plus1) ? pos_cur + POS_W'(1) : w_plus1;
  end

  // Ring addresses of the samples one row back and one row plus one back.
  always_comb begin
    base       = {1'b0, wr_ptr_q} + AX_W'(HIST_DEPTH);
    above_raw  = base - AX_W'(w_eff);
    ul_raw     = base - AX_W'(w_plus1);
    above_addr = (above_raw >= AX_W'(HIST_DEPTH)) ? HIST_AW'(above_raw - AX_W'(HIST_DEPTH))
                                                  : HIST_AW'(above_raw);
    ul_addr    = (ul_raw >= AX_W'(HIST_DEPTH)) ? HIST_AW'(ul_raw - AX_W'(HIST_DEPTH))
                                               : HIST_AW'(ul_raw);
    wr_ptr_d   = (wr_ptr_q == HIST_AW'(HIST_DEPTH - 1)) ? '0 : wr_ptr_q + HIST_AW'(1);
  end

  // Sample history: one write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (pred_acc) begin
      hist_mem[wr_ptr_q] <= in_data_i.sample;
      above_q            <= hist_mem[above_addr];
      ul_q               <= hist_mem[ul_addr];
    end
  end

  always_comb begin
    s1_v_d = s1_v_q;
    if (accept) begin
      s1_v_d = 1'b1;
    end else if (op_ready_i) begin
      s1_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      pos_q    <= '0;
      wr_ptr_q <= '0;
    end else begin
      s1_v_q <= s1_v_d;
      if (pred_acc) begin
        pos_q    <= pos_d;
        wr_ptr_q <= wr_ptr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q     <= in_data_i.opcode;
      s1_sample_q <= in_data_i.sample;
      s1_left_q   <= last_q;
      s1_sel_q    <= sel;
      s1_bin_q    <= in_data_i.bin_index;
      s1_clear_q  <= in_data_i.clear_bin;
    end
    if (pred_acc) begin
      last_q <= in_data_i.sample;
    end
  end

  // Second stage: prediction and residual, all arithmetic modulo 256.
  always_comb begin
    grad = above_q + s1_left_q - ul_q;
    case (s1_sel_q)
      SEL_FIRST:  pred = FIRST_PREDICTION;
      SEL_LEFT:   pred = s1_left_q;
      SEL_ABOVE:  pred = above_q;
      SEL_MEDIAN: pred = med3(above_q, s1_left_q, grad);
      default:    pred = FIRST_PREDICTION;
    endcase
    resid = s1_sample_q - pred;
  end

  assign op_valid_o     = s1_v_q;
  assign op_o.opcode    = s1_op_q;
  assign op_o.bin       = (s1_op_q == OP_READ) ? s1_bin_q : resid;
  assign op_o.clear_bin = s1_clear_q;

endmodule

`default_nettype wire

// ----- hdl/mprh_queue.sv -----
// Short queue of histogram operations between the front end and the back end.
`default_nettype none

module mprh_queue
  import mprh_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_valid_i,
  output logic          push_ready_o,
  input  wire hist_op_t push_i,
  output logic          pop_valid_o,
  input  wire logic     pop_ready_i,
  output hist_op_t      pop_o
);

  hist_op_t          entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_o        = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mprh_back.sv -----
// Back end: histogram read-modify-write with forwarding and the output register.
`default_nettype none

module mprh_back
  import mprh_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     op_valid_i,
  output logic          op_ready_o,
  input  wire hist_op_t op_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_item_t     out_data_o
);

  logic [COUNT_WIDTH-1:0] cnt_mem [BINS];
  logic [BINS-1:0]        bin_vld_q;

  logic                   pop;
  logic                   b1_v_q;
  logic                   b1_adv;
  hist_op_t               b1_op_q;
  logic [COUNT_WIDTH-1:0] rd_q;
  logic                   rd_vld_q;
  logic                   fwd_hit_q;
  logic [COUNT_WIDTH-1:0] fwd_data_q;
  logic [COUNT_WIDTH-1:0] cur;
  logic                   wr_en;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic                   out_v_q;
  out_item_t              out_q;

  assign b1_adv     = b1_v_q && (!out_v_q || out_ready_i);
  assign op_ready_o = !b1_v_q || b1_adv;
  assign pop        = op_valid_i && op_ready_o;

  // A write at the same edge as the read is not seen by the read; forward it.
  always_comb begin
    cur     = fwd_hit_q ? fwd_data_q : (rd_vld_q ? rd_q : '0);
    wr_en   = b1_adv && ((b1_op_q.opcode == OP_PREDICT) || b1_op_q.clear_bin);
    wr_data = '0;
    if (b1_op_q.opcode == OP_PREDICT) begin
      wr_data = (cur == '1) ? cur : cur + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      rd_q <= cnt_mem[op_i.bin];
    end
    if (wr_en) begin
      cnt_mem[b1_op_q.bin] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      b1_op_q    <= op_i;
      rd_vld_q   <= bin_vld_q[op_i.bin];
      fwd_hit_q  <= wr_en && (b1_op_q.bin == op_i.bin);
      fwd_data_q <= wr_data;
    end
    if (b1_adv) begin
      out_q.result_kind <= (b1_op_q.opcode == OP_READ) ? RK_BIN : RK_RESIDUAL;
      out_q.residual    <= (b1_op_q.opcode == OP_READ) ? '0 : b1_op_q.bin;
      out_q.bin_count   <= (b1_op_q.opcode == OP_READ) ? BIN_COUNT_W'(cur) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_vld_q <= '0;
      b1_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        bin_vld_q[b1_op_q.bin] <= 1'b1;
      end
      if (pop) begin
        b1_v_q <= 1'b1;
      end else if (b1_adv) begin
        b1_v_q <= 1'b0;
      end
      if (b1_adv) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- hdl/median_predict_residual_histogram_top.sv -----
// Top level of the median predictor with residual histogram.
//
//   Channel   Direction  Handshake                   Payload
//   input     in         in_valid_i / in_ready_o      in_data_i (in_item_t)
//   output    out        out_valid_o / out_ready_i    out_data_o (out_item_t)
//   config    APB        psel, penable, pwrite, pready paddr, pwdata, prdata
//
// The block takes one item per cycle, sustained, when the output side takes results
// as fast. One transfer on the input passes to its result through the front end stage
// with the history reads, the queue, the histogram read and the output register.
// The histogram read-modify-write forwards its own last write, so residuals that hit
// the same bin back to back keep the full rate.
// Reset clears the control state and all histogram bins at once through per-bin valid
// bits, so no clearing pass is needed. A stall at the output fills the queue first and
// then holds in_ready_o low; the front end stalls on its own only when the queue is full.
`default_nettype none

module median_predict_residual_histogram_top
  import mprh_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_data_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Register index is the word address.
  localparam logic REG_ROW_WIDTH    = 1'b0;
  localparam logic REG_PREDICT_MODE = 1'b1;

  logic                   cfg_wr;
  logic                   reg_idx;
  logic [ROW_WIDTH_W-1:0] row_width_q;
  logic                   predict_mode_q;

  logic     fq_valid, fq_ready;
  hist_op_t fq_op;
  logic     qb_valid, qb_ready;
  hist_op_t qb_op;

  // The port never waits, so a write completes in its access cycle.
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q    <= ROW_WIDTH_RESET;
      predict_mode_q <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ROW_WIDTH:    row_width_q    <= pwdata[ROW_WIDTH_W-1:0];
        REG_PREDICT_MODE: predict_mode_q <= pwdata[0];
        default:          row_width_q    <= row_width_q;
      endcase
    end
  end

  // Reads return the register selected by the address, zero extended.
  always_comb begin
    case (reg_idx)
      REG_ROW_WIDTH:    prdata = 32'(row_width_q);
      REG_PREDICT_MODE: prdata = 32'(predict_mode_q);
      default:          prdata = '0;
    endcase
  end

  // The front end classifies each item and turns samples into residuals.
  mprh_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_data_i      (in_data_i),
    .row_width_i    (row_width_q),
    .predict_mode_i (predict_mode_q),
    .op_valid_o     (fq_valid),
    .op_ready_i     (fq_ready),
    .op_o           (fq_op)
  );

  // The queue lets the two halves stall independently.
  mprh_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_i       (fq_op),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_o        (qb_op)
  );

  // The back end updates or reads the histogram and holds the result.
  mprh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (qb_valid),
    .op_ready_o  (qb_ready),
    .op_i        (qb_op),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- hdl/mprh_checker.sv -----
// Port-level checks of the median predictor top level and their binding.
`default_nettype none

module mprh_port_checker
  import mprh_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire out_item_t   out_data_o,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // The output register is cleared by the reset edge, so it is checked in the cycle after reset is sampled.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result shown during reset");

  a_kind_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.result_kind == RK_RESIDUAL && out_data_o.bin_count == '0) ||
                     (out_data_o.result_kind == RK_BIN && out_data_o.residual == '0)))
    else $error("result carries a field of the other kind");

  a_width_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && !paddr[2]) ##1 !paddr[2]
      |-> prdata[12:0] == $past(pwdata[12:0]))
    else $error("row width read back differs from the value written");

endmodule

bind median_predict_residual_histogram_top mprh_port_checker u_mprh_checker (.*);

`default_nettype wire
